// ===== design/fpfa_pkg.sv =====
// Shared types and codes for the fixed-partition fit allocator.
// Used by the top level; no dependencies.
package fpfa_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SIZE_BITS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_DONE
    } state_t;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOFIT  = 2'd1;
    localparam logic [1:0] STATUS_BADIDX = 2'd2;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic CFG_FIT_POLICY  = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

endpackage

// ===== design/fpfa_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module fpfa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fixed_partition_fit_allocator.sv =====
// Fixed-partition allocator: first, best or worst fit over stored slot sizes.
// A load goes straight to the done state; a request with active blocks runs scan,
// drain and commit (straight to done when no slot is active): one slot read per
// cycle from the single RAM port, then drain, write-back of the used bit of a granted
// slot. In done, m_valid is registered once the output is free; no request is taken
// until the block is back in idle. Reset clears control and config registers; the
// slot RAM is not cleared, so a slot must be loaded before any request scans it.
module fixed_partition_fit_allocator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [5:0]  s_slot_index,
    input  logic [15:0] s_amount,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_granted,
    output logic [5:0]  m_chosen_slot,
    output logic [15:0] m_chosen_size,
    output logic [15:0] m_leftover,
    output logic [1:0]  m_status
);

    localparam int MAX_SLOTS = fpfa_pkg::MAX_SLOTS;
    localparam int SIZE_BITS = fpfa_pkg::SIZE_BITS;
    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int WORD_W = SIZE_BITS + 1;

    fpfa_pkg::state_t state_reg, state_next;

    logic [1:0]           fit_policy_reg;
    logic [6:0]           block_count_reg;
    logic [6:0]           act_count;

    logic                 mode_reg;
    logic [SIZE_BITS-1:0] amt_reg;
    logic [1:0]           ld_status_reg;
    logic [6:0]           scan_cnt_reg;
    logic                 rd_vld_reg;
    logic [6:0]           rd_idx_reg;
    logic                 found_reg;
    logic [6:0]           best_idx_reg;
    logic [SIZE_BITS-1:0] best_size_reg;

    logic                 m_valid_reg;
    logic                 m_granted_reg;
    logic [5:0]           m_chosen_slot_reg;
    logic [15:0]          m_chosen_size_reg;
    logic [15:0]          m_leftover_reg;
    logic [1:0]           m_status_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 accept;
    logic                 load_in_range;
    logic                 scan_last;
    logic                 out_free;
    logic                 out_load;
    logic                 rd_used;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 fits;
    logic                 take;
    logic [SIZE_BITS-1:0] amt_in;

    // Active count saturates at the slot capacity
    assign act_count = (32'(block_count_reg) > MAX_SLOTS) ? 7'(MAX_SLOTS) : block_count_reg;

    assign amt_in        = SIZE_BITS'(s_amount);
    assign accept        = s_valid && s_ready;
    assign load_in_range = {1'b0, s_slot_index} < act_count;
    assign scan_last     = (scan_cnt_reg + 7'd1) == act_count;
    assign out_free      = !m_valid_reg || m_ready;

    assign rd_used = ram_rdata[SIZE_BITS];
    assign rd_size = ram_rdata[SIZE_BITS-1:0];
    assign fits    = rd_vld_reg && !rd_used && (rd_size >= amt_reg);
    assign take    = fits && (!found_reg
                     || (fit_policy_reg == fpfa_pkg::POLICY_BEST && rd_size < best_size_reg)
                     || (fit_policy_reg == fpfa_pkg::POLICY_WORST && rd_size > best_size_reg));

    fpfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fpfa_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_mode == fpfa_pkg::MODE_REQUEST && act_count != 7'd0) begin
                        state_next = fpfa_pkg::ST_SCAN;
                    end else begin
                        state_next = fpfa_pkg::ST_DONE;
                    end
                end
            end
            fpfa_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = fpfa_pkg::ST_DRAIN;
                end
            end
            fpfa_pkg::ST_DRAIN:  state_next = fpfa_pkg::ST_COMMIT;
            fpfa_pkg::ST_COMMIT: state_next = fpfa_pkg::ST_DONE;
            fpfa_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = fpfa_pkg::ST_IDLE;
                end
            end
            default: state_next = fpfa_pkg::ST_IDLE;
        endcase
    end

    // RAM port and handshake control
    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = IDX_W'(scan_cnt_reg);
        ram_wdata = {1'b1, best_size_reg};
        unique case (state_reg)
            fpfa_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ram_addr  = IDX_W'(s_slot_index);
                ram_wdata = {1'b0, amt_in};
                ram_we    = accept && s_mode == fpfa_pkg::MODE_LOAD && load_in_range;
            end
            fpfa_pkg::ST_SCAN: begin
                ram_addr = IDX_W'(scan_cnt_reg);
            end
            fpfa_pkg::ST_DRAIN: begin
                ram_addr = IDX_W'(best_idx_reg);
            end
            fpfa_pkg::ST_COMMIT: begin
                // mark the granted slot used
                ram_addr = IDX_W'(best_idx_reg);
                ram_we   = found_reg;
            end
            fpfa_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fpfa_pkg::ST_IDLE;
            fit_policy_reg  <= fpfa_pkg::POLICY_FIRST;
            block_count_reg <= 7'd0;
            rd_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            scan_cnt_reg    <= 7'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == fpfa_pkg::ST_SCAN);

            if (cfg_we) begin
                if (cfg_index == fpfa_pkg::CFG_FIT_POLICY) begin
                    fit_policy_reg <= cfg_wdata[1:0];
                end else begin
                    block_count_reg <= cfg_wdata;
                end
            end

            if (accept) begin
                found_reg    <= 1'b0;
                scan_cnt_reg <= 7'd0;
            end else begin
                if (state_reg == fpfa_pkg::ST_SCAN) begin
                    scan_cnt_reg <= scan_cnt_reg + 7'd1;
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg      <= s_mode;
            amt_reg       <= amt_in;
            ld_status_reg <= load_in_range ? fpfa_pkg::STATUS_OK : fpfa_pkg::STATUS_BADIDX;
        end
        rd_idx_reg <= scan_cnt_reg;
        if (take) begin
            best_idx_reg  <= rd_idx_reg;
            best_size_reg <= rd_size;
        end
        if (out_load) begin
            if (mode_reg == fpfa_pkg::MODE_LOAD) begin
                m_granted_reg     <= 1'b0;
                m_chosen_slot_reg <= 6'd0;
                m_chosen_size_reg <= 16'd0;
                m_leftover_reg    <= 16'd0;
                m_status_reg      <= ld_status_reg;
            end else if (found_reg) begin
                m_granted_reg     <= 1'b1;
                m_chosen_slot_reg <= 6'(best_idx_reg);
                m_chosen_size_reg <= 16'(best_size_reg);
                m_leftover_reg    <= 16'(best_size_reg - amt_reg);
                m_status_reg      <= fpfa_pkg::STATUS_OK;
            end else begin
                m_granted_reg     <= 1'b0;
                m_chosen_slot_reg <= 6'd0;
                m_chosen_size_reg <= 16'd0;
                m_leftover_reg    <= 16'd0;
                m_status_reg      <= fpfa_pkg::STATUS_NOFIT;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_granted     = m_granted_reg;
    assign m_chosen_slot = m_chosen_slot_reg;
    assign m_chosen_size = m_chosen_size_reg;
    assign m_leftover    = m_leftover_reg;
    assign m_status      = m_status_reg;

    a_ram_write_idle_or_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == fpfa_pkg::ST_IDLE || state_reg == fpfa_pkg::ST_COMMIT))
        else $error("slot RAM written during scan");

    a_request_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == fpfa_pkg::MODE_REQUEST && act_count != 7'd0)
        |=> state_reg == fpfa_pkg::ST_SCAN)
        else $error("request did not start a scan");

    a_grant_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_granted) |-> (m_status == fpfa_pkg::STATUS_OK
                                    && m_leftover <= m_chosen_size))
        else $error("granted result inconsistent");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fpfa_pkg::ST_IDLE) |-> !s_ready)
        else $error("request accepted while busy");

endmodule
